@@ src/bfld_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfld_pkg
// shared types and constants of the box filter line decimator
// ----------------------------------------------------------------------------
package bfld_pkg;

    localparam int CFG_W    = 13;   // width registers
    localparam int COEF_W   = 48;   // gain and offset
    localparam int SAMPLE_W = 32;
    localparam int SUM_W    = 44;   // running sum of one box
    localparam int AVG_W    = 40;
    localparam int IDX_W    = 12;
    localparam int FRAC_BITS = 8;
    localparam int NUM_W    = SUM_W + FRAC_BITS;   // dividend magnitude
    localparam int ERR_W    = CFG_W + 2;           // boundary error term
    localparam int ACC_W    = 90;                  // display accumulator
    localparam int DISP_SHIFT = FRAC_BITS + 32;    // fraction bits of the product
    localparam int OFS_SHIFT  = FRAC_BITS + 16;    // aligns offset to the product

    localparam logic [1:0] REG_IN_WIDTH  = 2'd0;
    localparam logic [1:0] REG_OUT_WIDTH = 2'd1;
    localparam logic [1:0] REG_GAIN      = 2'd2;
    localparam logic [1:0] REG_OFFSET    = 2'd3;

    localparam logic [7:0] BYTE_MASK = 8'hFF;

    // one finished box handed from front to back
    typedef struct packed {
        logic signed [SUM_W-1:0] sum;
        logic [CFG_W-1:0]        count;
        logic [IDX_W-1:0]        index;
        logic                    last;
    } job_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_DIV,
        BK_MUL,
        BK_DONE
    } back_state_t;

endpackage

@@ src/box_filter_line_decimator.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// box_filter_line_decimator
// shrinks an image line by box averaging, one sample per input beat
// ----------------------------------------------------------------------------
// usage
// - input side: drive sample with push; a beat is taken when push is high and
//   full is low. samples of one line come in order, in_width per line.
// - result side: while empty is low the oldest result sits on avg_value,
//   display_byte, out_index and last_of_line; pop takes it.
// - configuration: wr_en, wr_index, wr_data write one register per clock.
//   a write to in_width or out_width restarts the line; gain and offset
//   apply from the next result on.
// - throughput: the front takes one sample per cycle while full is low. the
//   back end works on one box at a time: the bit-serial divider, then the
//   four split partial products of the display multiply.
// - a two-entry job queue sits between front and back; full rises when it
//   holds two boxes, so narrow boxes back-pressure the input.
// - a stalled result holds its ports until popped; the back end keeps
//   working on the next box meanwhile.
// - reset clears line position, queue and output register; widths go to 2,
//   gain to 1.0, offset to 0.
// ----------------------------------------------------------------------------
module box_filter_line_decimator
    import bfld_pkg::*;
#(
    parameter int MAX_WIDTH = 4096
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    output logic                       full,
    input  logic signed [SAMPLE_W-1:0] sample,
    output logic                       empty,
    input  logic                       pop,
    output logic signed [AVG_W-1:0]    avg_value,
    output logic [7:0]                 display_byte,
    output logic [IDX_W-1:0]           out_index,
    output logic                       last_of_line,
    input  logic                       wr_en,
    input  logic [1:0]                 wr_index,
    input  logic [COEF_W-1:0]          wr_data
);

    logic [CFG_W-1:0]         in_width_reg;
    logic [CFG_W-1:0]         out_width_reg;
    logic signed [COEF_W-1:0] gain_reg;
    logic signed [COEF_W-1:0] offset_reg;
    logic                     clear;
    logic                     accept;
    logic                     job_push;
    job_t                     push_job;
    logic                     job_valid;
    logic                     job_pop;
    job_t                     head_job;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_width_reg  <= CFG_W'(2);
            out_width_reg <= CFG_W'(2);
            gain_reg      <= COEF_W'(64'h1_0000_0000);
            offset_reg    <= '0;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                REG_IN_WIDTH:  in_width_reg  <= wr_data[CFG_W-1:0];
                REG_OUT_WIDTH: out_width_reg <= wr_data[CFG_W-1:0];
                REG_GAIN:      gain_reg      <= wr_data;
                REG_OFFSET:    offset_reg    <= wr_data;
                default:       ;
            endcase
        end
    end

    assign clear  = wr_en && (wr_index == REG_IN_WIDTH || wr_index == REG_OUT_WIDTH);
    assign accept = push && !full;

    bfld_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .sample    (sample),
        .in_width  (in_width_reg),
        .out_width (out_width_reg),
        .clear     (clear),
        .job_push  (job_push),
        .job       (push_job)
    );

    bfld_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (job_push),
        .push_job (push_job),
        .pop      (job_pop),
        .full     (full),
        .valid    (job_valid),
        .head     (head_job)
    );

    bfld_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .job_valid    (job_valid),
        .job          (head_job),
        .job_pop      (job_pop),
        .gain         (gain_reg),
        .offset       (offset_reg),
        .pop          (pop),
        .empty        (empty),
        .avg_value    (avg_value),
        .display_byte (display_byte),
        .out_index    (out_index),
        .last_of_line (last_of_line)
    );

endmodule

@@ src/bfld_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfld_front
// accumulates samples and finds box boundaries without a divider
// ----------------------------------------------------------------------------
module bfld_front
    import bfld_pkg::*;
#(
    parameter int MAX_WIDTH = 4096
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       accept,
    input  logic signed [SAMPLE_W-1:0] sample,
    input  logic [CFG_W-1:0]           in_width,
    input  logic [CFG_W-1:0]           out_width,
    input  logic                       clear,
    output logic                       job_push,
    output job_t                       job
);

    logic [CFG_W-1:0]        iw;
    logic [CFG_W-1:0]        ow;
    logic [CFG_W-1:0]        span_in;
    logic [CFG_W-1:0]        span_out;
    logic [ERR_W-1:0]        err_reg;
    logic [CFG_W-1:0]        pos_reg;
    logic signed [SUM_W-1:0] sum_reg;
    logic [CFG_W-1:0]        count_reg;
    logic signed [SUM_W-1:0] sum_next;
    logic [CFG_W-1:0]        count_next;
    logic                    emit;
    logic                    last;

    // clamp widths to legal range
    always_comb
    begin
        if (in_width < CFG_W'(2))
            iw = CFG_W'(2);
        else if (int'(in_width) > MAX_WIDTH)
            iw = CFG_W'(MAX_WIDTH);
        else
            iw = in_width;
        if (out_width < CFG_W'(2))
            ow = CFG_W'(2);
        else if (out_width > iw)
            ow = iw;
        else
            ow = out_width;
        span_in  = iw - CFG_W'(1);
        span_out = ow - CFG_W'(1);
    end

    // err = p*(iw-1) - j*(ow-1); box ends where err < ow-1
    always_comb
    begin
        sum_next   = sum_reg + SUM_W'(sample);
        count_next = count_reg + CFG_W'(1);
        emit       = err_reg < ERR_W'(span_out);
        last       = pos_reg == span_out;
        job_push   = accept && emit;
        job.sum    = sum_next;
        job.count  = count_next;
        job.index  = pos_reg[IDX_W-1:0];
        job.last   = last;
    end

    // line state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            err_reg   <= '0;
            pos_reg   <= '0;
            sum_reg   <= '0;
            count_reg <= '0;
        end
        else if (clear || (accept && emit && last))
        begin
            err_reg   <= '0;
            pos_reg   <= '0;
            sum_reg   <= '0;
            count_reg <= '0;
        end
        else if (accept && emit)
        begin
            err_reg   <= err_reg + ERR_W'(span_in) - ERR_W'(span_out);
            pos_reg   <= pos_reg + CFG_W'(1);
            sum_reg   <= '0;
            count_reg <= '0;
        end
        else if (accept)
        begin
            err_reg   <= err_reg - ERR_W'(span_out);
            sum_reg   <= sum_next;
            count_reg <= count_next;
        end
    end

endmodule

@@ src/bfld_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfld_queue
// two entry job queue between front and back
// ----------------------------------------------------------------------------
module bfld_queue
    import bfld_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_job,
    input  logic pop,
    output logic full,
    output logic valid,
    output job_t head
);

    job_t       mem_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] fill_reg;

    assign full  = fill_reg == 2'd2;
    assign valid = fill_reg != 2'd0;
    assign head  = mem_reg[rd_ptr_reg];

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_job;
    end

    // pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            if (push && !pop)
                fill_reg <= fill_reg + 2'd1;
            else if (pop && !push)
                fill_reg <= fill_reg - 2'd1;
        end
    end

endmodule

@@ src/bfld_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfld_back
// serial divider for the average, split multiply for the display byte
// ----------------------------------------------------------------------------
module bfld_back
    import bfld_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     job_valid,
    input  job_t                     job,
    output logic                     job_pop,
    input  logic signed [COEF_W-1:0] gain,
    input  logic signed [COEF_W-1:0] offset,
    input  logic                     pop,
    output logic                     empty,
    output logic signed [AVG_W-1:0]  avg_value,
    output logic [7:0]               display_byte,
    output logic [IDX_W-1:0]         out_index,
    output logic                     last_of_line
);

    localparam int CNT_W = $clog2(NUM_W);

    back_state_t              state_reg;
    back_state_t              state_next;
    logic [NUM_W-1:0]         num_reg;
    logic [CFG_W-1:0]         rem_reg;
    logic [CFG_W-1:0]         div_reg;
    logic                     neg_reg;
    logic [IDX_W-1:0]         idx_reg;
    logic                     last_reg;
    logic [CNT_W-1:0]         cnt_reg;
    logic signed [AVG_W-1:0]  avg_reg;
    logic signed [65:0]       prod_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic                     out_valid_reg;
    logic                     load;
    logic [SUM_W-1:0]         sum_mag;
    logic [CFG_W:0]           trial;
    logic                     qbit;
    logic signed [32:0]       opa;
    logic signed [32:0]       opb;
    logic signed [ACC_W-1:0]  prod_ext;
    logic signed [ACC_W-1:0]  prod_shift;
    logic [7:0]               disp;

    // control
    always_comb
    begin
        state_next = state_reg;
        job_pop    = 1'b0;
        load       = 1'b0;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (job_valid)
                begin
                    job_pop    = 1'b1;
                    state_next = BK_DIV;
                end
            end
            BK_DIV:
            begin
                if (cnt_reg == CNT_W'(NUM_W - 1))
                    state_next = BK_MUL;
            end
            BK_MUL:
            begin
                if (cnt_reg == CNT_W'(5))
                    state_next = BK_DONE;
            end
            BK_DONE:
            begin
                if (!out_valid_reg || pop)
                begin
                    load       = 1'b1;
                    state_next = BK_IDLE;
                end
            end
            default: state_next = BK_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= BK_IDLE;
        else
            state_reg <= state_next;
    end

    // one restoring division step
    always_comb
    begin
        sum_mag = job.sum[SUM_W-1] ? SUM_W'(-job.sum) : SUM_W'(job.sum);
        trial   = {rem_reg, num_reg[NUM_W-1]};
        qbit    = trial >= {1'b0, div_reg};
    end

    // partial product operands, four pieces of avg * gain
    always_comb
    begin
        opa = '0;
        opb = '0;
        case (cnt_reg)
            CNT_W'(1):
            begin
                opa = {1'b0, avg_reg[31:0]};
                opb = {1'b0, gain[31:0]};
            end
            CNT_W'(2):
            begin
                opa = {1'b0, avg_reg[31:0]};
                opb = 33'($signed(gain[COEF_W-1:32]));
            end
            CNT_W'(3):
            begin
                opa = 33'($signed(avg_reg[AVG_W-1:32]));
                opb = {1'b0, gain[31:0]};
            end
            CNT_W'(4):
            begin
                opa = 33'($signed(avg_reg[AVG_W-1:32]));
                opb = 33'($signed(gain[COEF_W-1:32]));
            end
            default:
            begin
                opa = '0;
                opb = '0;
            end
        endcase
        prod_ext = ACC_W'(prod_reg);
        case (cnt_reg)
            CNT_W'(3), CNT_W'(4): prod_shift = prod_ext <<< 32;
            CNT_W'(5):            prod_shift = prod_ext <<< 64;
            default:              prod_shift = prod_ext;
        endcase
    end

    // truncate toward zero, keep low byte of the integer part
    assign disp = acc_reg[DISP_SHIFT+7:DISP_SHIFT]
                + {7'd0, acc_reg[ACC_W-1] && (acc_reg[DISP_SHIFT-1:0] != '0)};

    // datapath
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            BK_IDLE:
            begin
                num_reg  <= {sum_mag, FRAC_BITS'(0)};
                neg_reg  <= job.sum[SUM_W-1];
                div_reg  <= job.count;
                rem_reg  <= '0;
                idx_reg  <= job.index;
                last_reg <= job.last;
                cnt_reg  <= '0;
            end
            BK_DIV:
            begin
                rem_reg <= qbit ? CFG_W'(trial - {1'b0, div_reg}) : trial[CFG_W-1:0];
                num_reg <= {num_reg[NUM_W-2:0], qbit};
                cnt_reg <= (cnt_reg == CNT_W'(NUM_W - 1)) ? '0 : cnt_reg + CNT_W'(1);
            end
            BK_MUL:
            begin
                if (cnt_reg == '0)
                begin
                    avg_reg <= neg_reg ? -AVG_W'(num_reg) : AVG_W'(num_reg);
                    acc_reg <= ACC_W'(offset) <<< OFS_SHIFT;
                end
                if (cnt_reg >= CNT_W'(1) && cnt_reg <= CNT_W'(4))
                    prod_reg <= opa * opb;
                if (cnt_reg >= CNT_W'(2))
                    acc_reg <= acc_reg + prod_shift;
                cnt_reg <= cnt_reg + CNT_W'(1);
            end
            BK_DONE:
            begin
                if (load)
                begin
                    avg_value    <= avg_reg;
                    display_byte <= disp & BYTE_MASK;
                    out_index    <= idx_reg;
                    last_of_line <= last_reg;
                end
            end
            default:
            begin
                cnt_reg <= '0;
            end
        endcase
    end

    // output beat register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (load)
            out_valid_reg <= 1'b1;
        else if (pop)
            out_valid_reg <= 1'b0;
    end

    assign empty = !out_valid_reg;

endmodule

@@ src/bfld_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfld_checker
// port level checks of the box filter line decimator
// ----------------------------------------------------------------------------
module bfld_checker
    import bfld_pkg::*;
(
    input logic                    clk,
    input logic                    rst_n,
    input logic                    empty,
    input logic                    pop,
    input logic signed [AVG_W-1:0] avg_value,
    input logic [7:0]              display_byte,
    input logic [IDX_W-1:0]        out_index,
    input logic                    last_of_line
);

    // a line always has at least two outputs
    a_last_not_first: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && last_of_line) |-> (out_index != '0))
        else $error("last result of a line at index zero");

    // nothing is waiting right after reset
    a_empty_after_reset: assert property (@(posedge clk)
        $rose(rst_n) |-> empty)
        else $error("result present after reset");

    // a stalled result beat holds its payload
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(avg_value) && $stable(display_byte)
                              && $stable(out_index) && $stable(last_of_line)))
        else $error("stalled result changed");

endmodule

bind box_filter_line_decimator bfld_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .empty        (empty),
    .pop          (pop),
    .avg_value    (avg_value),
    .display_byte (display_byte),
    .out_index    (out_index),
    .last_of_line (last_of_line)
);
